// ===== src/lzss_pkg.sv =====
// Shared types, constants and defaults of the LZSS stream decompressor.
`timescale 1ns / 1ps

package lzss_pkg;

   // Fixed field widths.
   localparam int BYTE_W    = 8;
   localparam int BUF_W     = 24;
   localparam int CNT_W     = 5;
   localparam int OUT_LEN_W = 32;

   // Defaults of the top-level parameters.
   localparam int DEF_WINDOW_SIZE = 8192;
   localparam int DEF_OFFSET_BITS = 13;
   localparam int DEF_LENGTH_BITS = 4;
   localparam int DEF_MIN_MATCH   = 3;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_READ,
      ST_WRITE,
      ST_FINISH
   } state_type;

   // Which token field the bit reader expects next.
   typedef enum logic [1:0] {
      PH_FLAG,
      PH_LITERAL,
      PH_OFFSET,
      PH_LENGTH
   } phase_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic pad;
      logic take;
      logic stop_met;
      logic rd;
      logic copy_push;
      logic copy_end;
      logic flush;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic      stopped;
      phase_type phase;
      logic      short_bits;
      logic      len_met;
      logic      end_marker;
      logic      copy_done;
      logic      can_push;
      logic      out_free;
      logic      hold_valid;
      logic      last_flag;
   } dp_status_type;

endpackage

// ===== src/lzss_ctrl.sv =====
// Token sequencer of the LZSS stream decompressor.
`timescale 1ns / 1ps

module lzss_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_first_byte,
   output logic                   req_stall,
   input  lzss_pkg::dp_status_type sts,
   output lzss_pkg::ctrl_cmd_type  cmd
);
   import lzss_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      needs_slot;

   // A literal or an end marker may place a result in the hold stage.
   assign needs_slot = (sts.phase == PH_LITERAL) || (sts.phase == PH_OFFSET);

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_first_byte || !sts.stopped)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.len_met) begin
               if (sts.can_push) begin
                  state_in = ST_FINISH;
               end
            end else if (sts.short_bits) begin
               if (!sts.last_flag) begin
                  state_in = ST_FINISH;
               end
            end else if (!needs_slot || sts.can_push) begin
               case (sts.phase)
                  PH_LENGTH: state_in = ST_READ;
                  PH_OFFSET: state_in = sts.end_marker ? ST_FINISH : ST_CHECK;
                  default:   state_in = ST_CHECK;
               endcase
            end
         end
         ST_READ: begin
            state_in = (sts.len_met || sts.copy_done) ? ST_CHECK : ST_WRITE;
         end
         ST_WRITE: begin
            if (sts.can_push) begin
               state_in = ST_READ;
            end
         end
         ST_FINISH: begin
            if (!sts.hold_valid || sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands and input handshake.
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_CHECK: begin
            if (sts.len_met) begin
               cmd.stop_met = sts.can_push;
            end else if (sts.short_bits) begin
               cmd.pad = sts.last_flag;
            end else begin
               cmd.take = !needs_slot || sts.can_push;
            end
         end
         ST_READ: begin
            if (sts.len_met || sts.copy_done) begin
               cmd.copy_end = 1'b1;
            end else begin
               cmd.rd = 1'b1;
            end
         end
         ST_WRITE: begin
            cmd.copy_push = sts.can_push;
         end
         ST_FINISH: begin
            cmd.flush = sts.hold_valid && sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== src/lzss_datapath.sv =====
// Bit reader, window memory, counters and result stages of the LZSS decompressor.
`timescale 1ns / 1ps

module lzss_datapath #(
   parameter int WINDOW_SIZE = lzss_pkg::DEF_WINDOW_SIZE,
   parameter int OFFSET_BITS = lzss_pkg::DEF_OFFSET_BITS,
   parameter int LENGTH_BITS = lzss_pkg::DEF_LENGTH_BITS,
   parameter int MIN_MATCH   = lzss_pkg::DEF_MIN_MATCH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lzss_pkg::ctrl_cmd_type            cmd,
   output lzss_pkg::dp_status_type           sts,
   input  logic [lzss_pkg::BYTE_W-1:0]       req_in_byte,
   input  logic                              req_first_byte,
   input  logic                              req_last_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [lzss_pkg::BYTE_W-1:0]       rsp_out_byte,
   output logic                              rsp_byte_valid,
   output logic                              rsp_run_last,
   output logic                              rsp_done_res,
   output logic                              rsp_length_met,
   input  logic                              csr_wr_en,
   input  logic [lzss_pkg::OUT_LEN_W-1:0]    csr_wr_data
);
   import lzss_pkg::*;

   localparam int ADDR_W = $clog2(WINDOW_SIZE);
   localparam int FILL_W = ADDR_W + 1;
   localparam int LEN_W  = LENGTH_BITS + 1;
   localparam int TAKE_W = (OFFSET_BITS > BYTE_W) ? OFFSET_BITS : BYTE_W;
   localparam int SUM_W  = ((OFFSET_BITS > ADDR_W) ? OFFSET_BITS : ADDR_W) + LEN_W + 1;

   // Window memory.
   logic [BYTE_W-1:0] win_mem [WINDOW_SIZE];

   // Stream state.
   logic [BUF_W-1:0]       buf_ff, buf_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   phase_type              phase_ff, phase_in;
   logic [OFFSET_BITS-1:0] pending_ff, pending_in;
   logic [ADDR_W-1:0]      head_ff, head_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic [OUT_LEN_W-1:0]   emitted_ff, emitted_in;
   logic                   stopped_ff, stopped_in;
   logic                   last_ff, last_in;
   logic [LEN_W-1:0]       copy_len_ff, copy_len_in;
   logic [LEN_W-1:0]       copy_idx_ff, copy_idx_in;
   logic [OUT_LEN_W-1:0]   out_len_ff, out_len_in;

   // Window read port.
   logic [BYTE_W-1:0] rd_data_ff;
   logic              rd_ok_ff, rd_ok_in;
   logic [SUM_W-1:0]  rd_sum;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] rd_rel;
   logic              wr_en;
   logic [BYTE_W-1:0] wr_data;

   // Hold stage and output register.
   logic              hold_valid_ff, hold_valid_in;
   logic [BYTE_W-1:0] hold_byte_ff, hold_byte_in;
   logic              hold_bv_ff, hold_bv_in;
   logic              hold_done_ff, hold_done_in;
   logic              hold_met_ff, hold_met_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_bv_ff, rsp_bv_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_done_ff, rsp_done_in;
   logic              rsp_met_ff, rsp_met_in;

   // Bit extraction.
   logic [CNT_W-1:0]  need;
   logic [BUF_W-1:0]  shifted;
   logic [BUF_W-1:0]  field_mask;
   logic [TAKE_W-1:0] take_val;

   // Result push.
   logic              push;
   logic [BYTE_W-1:0] push_byte;
   logic              push_bv;
   logic              push_done;
   logic              push_met;
   logic              out_free;
   logic              emit;

   // Field width of the current token phase.
   always_comb begin
      case (phase_ff)
         PH_FLAG:    need = CNT_W'(1);
         PH_LITERAL: need = CNT_W'(BYTE_W);
         PH_OFFSET:  need = CNT_W'(OFFSET_BITS);
         default:    need = CNT_W'(LENGTH_BITS);
      endcase
   end

   // The oldest unread bits sit just below the fill level of the buffer.
   assign shifted    = buf_ff >> (cnt_ff - need);
   assign field_mask = ~({BUF_W{1'b1}} << need);
   assign take_val   = TAKE_W'(shifted & field_mask);

   // Window read address wraps around the window.
   assign rd_sum  = SUM_W'(pending_ff) + SUM_W'(copy_idx_ff);
   assign rd_addr = rd_sum[ADDR_W-1:0];
   assign rd_rel  = rd_addr - ADDR_W'(1);

   // An entry counts as written once the head has passed it since stream start.
   assign rd_ok_in = {1'b0, rd_rel} < fill_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Status toward the controller.
   always_comb begin
      sts.stopped    = stopped_ff;
      sts.phase      = phase_ff;
      sts.short_bits = cnt_ff < need;
      sts.len_met    = emitted_ff >= out_len_ff;
      sts.end_marker = take_val == '0;
      sts.copy_done  = copy_idx_ff == copy_len_ff;
      sts.can_push   = !hold_valid_ff || out_free;
      sts.out_free   = out_free;
      sts.hold_valid = hold_valid_ff;
      sts.last_flag  = last_ff;
   end

   // Stream state update.
   always_comb begin
      buf_in      = buf_ff;
      cnt_in      = cnt_ff;
      phase_in    = phase_ff;
      pending_in  = pending_ff;
      head_in     = head_ff;
      fill_in     = fill_ff;
      emitted_in  = emitted_ff;
      stopped_in  = stopped_ff;
      last_in     = last_ff;
      copy_len_in = copy_len_ff;
      copy_idx_in = copy_idx_ff;
      out_len_in  = out_len_ff;
      push        = 1'b0;
      push_byte   = '0;
      push_bv     = 1'b0;
      push_done   = 1'b0;
      push_met    = 1'b0;
      emit        = 1'b0;
      wr_en       = 1'b0;
      wr_data     = '0;

      if (csr_wr_en) begin
         out_len_in = csr_wr_data;
      end

      // New beat: a stream start clears the state before the byte is used.
      if (cmd.accept) begin
         if (req_first_byte) begin
            buf_in     = BUF_W'(req_in_byte);
            cnt_in     = CNT_W'(BYTE_W);
            phase_in   = PH_FLAG;
            pending_in = '0;
            head_in    = ADDR_W'(1);
            fill_in    = '0;
            emitted_in = '0;
            stopped_in = 1'b0;
            last_in    = req_last_byte;
         end else if (!stopped_ff) begin
            buf_in  = {buf_ff[BUF_W-BYTE_W-1:0], req_in_byte};
            cnt_in  = cnt_ff + CNT_W'(BYTE_W);
            last_in = req_last_byte;
         end
      end

      // Past the final beat, missing bits read as zero.
      if (cmd.pad) begin
         buf_in = {buf_ff[BUF_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
         cnt_in = cnt_ff + CNT_W'(BYTE_W);
      end

      if (cmd.take) begin
         cnt_in = cnt_ff - need;
         case (phase_ff)
            PH_FLAG: begin
               phase_in = take_val[0] ? PH_LITERAL : PH_OFFSET;
            end
            PH_LITERAL: begin
               push      = 1'b1;
               push_byte = take_val[BYTE_W-1:0];
               push_bv   = 1'b1;
               emit      = 1'b1;
               wr_en     = 1'b1;
               wr_data   = take_val[BYTE_W-1:0];
               phase_in  = PH_FLAG;
            end
            PH_OFFSET: begin
               if (take_val == '0) begin
                  phase_in   = PH_FLAG;
                  stopped_in = 1'b1;
                  push       = 1'b1;
                  push_done  = 1'b1;
               end else begin
                  pending_in = take_val[OFFSET_BITS-1:0];
                  phase_in   = PH_LENGTH;
               end
            end
            default: begin
               copy_len_in = LEN_W'(take_val[LENGTH_BITS-1:0]) + LEN_W'(MIN_MATCH);
               copy_idx_in = '0;
            end
         endcase
      end

      // Output length reached at a token boundary.
      if (cmd.stop_met) begin
         stopped_in = 1'b1;
         push       = 1'b1;
         push_done  = 1'b1;
         push_met   = 1'b1;
      end

      if (cmd.rd) begin
         copy_idx_in = copy_idx_ff + LEN_W'(1);
      end

      // Copied byte: never-written entries read as zero.
      if (cmd.copy_push) begin
         push      = 1'b1;
         push_byte = rd_ok_ff ? rd_data_ff : '0;
         push_bv   = 1'b1;
         emit      = 1'b1;
         wr_en     = 1'b1;
         wr_data   = rd_ok_ff ? rd_data_ff : '0;
      end

      if (cmd.copy_end) begin
         phase_in = PH_FLAG;
      end

      // Every produced byte advances the head and the counters.
      if (emit) begin
         head_in    = head_ff + ADDR_W'(1);
         emitted_in = emitted_ff + OUT_LEN_W'(1);
         if (fill_ff != FILL_W'(WINDOW_SIZE)) begin
            fill_in = fill_ff + FILL_W'(1);
         end
      end
   end

   // Hold stage and output register: a held result leaves once the next one
   // arrives, or with run_last set when the beat's work ends.
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_byte_in  = hold_byte_ff;
      hold_bv_in    = hold_bv_ff;
      hold_done_in  = hold_done_ff;
      hold_met_in   = hold_met_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_byte_in   = rsp_byte_ff;
      rsp_bv_in     = rsp_bv_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_met_in    = rsp_met_ff;

      if ((push && hold_valid_ff) || cmd.flush) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = hold_byte_ff;
         rsp_bv_in    = hold_bv_ff;
         rsp_last_in  = cmd.flush;
         rsp_done_in  = hold_done_ff;
         rsp_met_in   = hold_met_ff;
      end

      if (push) begin
         hold_valid_in = 1'b1;
         hold_byte_in  = push_byte;
         hold_bv_in    = push_bv;
         hold_done_in  = push_done;
         hold_met_in   = push_met;
      end else if (cmd.flush) begin
         hold_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         phase_ff      <= PH_FLAG;
         head_ff       <= ADDR_W'(1);
         fill_ff       <= '0;
         emitted_ff    <= '0;
         stopped_ff    <= 1'b0;
         last_ff       <= 1'b0;
         copy_len_ff   <= '0;
         copy_idx_ff   <= '0;
         out_len_ff    <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cnt_ff        <= cnt_in;
         phase_ff      <= phase_in;
         head_ff       <= head_in;
         fill_ff       <= fill_in;
         emitted_ff    <= emitted_in;
         stopped_ff    <= stopped_in;
         last_ff       <= last_in;
         copy_len_ff   <= copy_len_in;
         copy_idx_ff   <= copy_idx_in;
         out_len_ff    <= out_len_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff     <= '0;
         pending_ff <= '0;
      end else begin
         buf_ff     <= buf_in;
         pending_ff <= pending_in;
      end
      hold_byte_ff <= hold_byte_in;
      hold_bv_ff   <= hold_bv_in;
      hold_done_ff <= hold_done_in;
      hold_met_ff  <= hold_met_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_bv_ff    <= rsp_bv_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_met_ff   <= rsp_met_in;
   end

   // Window memory: one write at the head, one registered read.
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_data_ff <= win_mem[rd_addr];
         rd_ok_ff   <= rd_ok_in;
      end
      if (wr_en) begin
         win_mem[head_ff] <= wr_data;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_byte_valid = rsp_bv_ff;
   assign rsp_run_last   = rsp_last_ff;
   assign rsp_done_res   = rsp_done_ff;
   assign rsp_length_met = rsp_met_ff;

endmodule

// ===== src/lzss_stream_decompressor.sv =====
// Top level of the LZSS stream decompressor: sequencer plus datapath.
//
//   Channel  Ports                                    Direction  Beat
//   req      req_valid/req_stall, in_byte, first/last in         one compressed byte
//   rsp      rsp_valid/rsp_stall, out_byte and flags  out        one output byte or status
//   csr      csr_wr_en, csr_wr_data                   in         output length write
//
// A beat is taken in the idle state; each token field is then taken in a
// check step, a padding step appends a zero byte, and each copied byte is
// a window read, then a write and push, with one more read step to end the
// match. The beat closes with the check that finds too few bits and the
// flush of the held result. No new beat is taken until the sequencer is back
// in idle. The window read-then-write sequence sets the copy rate.
// Reset is synchronous; no clearing pass runs, a fill count marks which window
// entries have been written since stream start. A stalled result waits in the
// output register while the next one waits in a hold stage; the sequencer
// pauses when both are full.
`timescale 1ns / 1ps

module lzss_stream_decompressor #(
   parameter int WINDOW_SIZE = lzss_pkg::DEF_WINDOW_SIZE,
   parameter int OFFSET_BITS = lzss_pkg::DEF_OFFSET_BITS,
   parameter int LENGTH_BITS = lzss_pkg::DEF_LENGTH_BITS,
   parameter int MIN_MATCH   = lzss_pkg::DEF_MIN_MATCH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [lzss_pkg::BYTE_W-1:0]    req_in_byte,
   input  logic                           req_first_byte,
   input  logic                           req_last_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [lzss_pkg::BYTE_W-1:0]    rsp_out_byte,
   output logic                           rsp_byte_valid,
   output logic                           rsp_run_last,
   output logic                           rsp_done_res,
   output logic                           rsp_length_met,
   input  logic                           csr_wr_en,
   input  logic [lzss_pkg::OUT_LEN_W-1:0] csr_wr_data
);
   import lzss_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type sts;

   // Sequencer.
   lzss_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_first_byte (req_first_byte),
      .req_stall      (req_stall),
      .sts            (sts),
      .cmd            (cmd)
   );

   // Datapath.
   lzss_datapath #(
      .WINDOW_SIZE (WINDOW_SIZE),
      .OFFSET_BITS (OFFSET_BITS),
      .LENGTH_BITS (LENGTH_BITS),
      .MIN_MATCH   (MIN_MATCH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_in_byte    (req_in_byte),
      .req_first_byte (req_first_byte),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_run_last   (rsp_run_last),
      .rsp_done_res   (rsp_done_res),
      .rsp_length_met (rsp_length_met),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   // A status beat never carries a data byte.
   a_status_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |-> !rsp_byte_valid)
      else $error("status beat marked as data");

   // A new input beat only arrives once the previous beat's results are flushed.
   a_accept_hold_empty: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !sts.hold_valid)
      else $error("input beat accepted with a held result");

   // Reaching the output length stops the stream.
   a_stop_sets_flag: assert property (@(posedge clock) disable iff (reset)
      cmd.stop_met |=> sts.stopped)
      else $error("length stop did not set the stopped flag");

endmodule

// ===== tb/sv/lzss_stream_decompressor_tb.sv =====
// Self-checking testbench for the LZSS stream decompressor with its own decode model.
`timescale 1ns / 1ps

module lzss_stream_decompressor_tb;
   import lzss_pkg::*;

   localparam int WIN_SIZE      = DEF_WINDOW_SIZE;
   localparam int OFF_W         = DEF_OFFSET_BITS;
   localparam int LEN_W         = DEF_LENGTH_BITS;
   localparam int MIN_M         = DEF_MIN_MATCH;
   localparam int IDLE_PCT      = 27;
   localparam int SETTLE_CYCLES = 64;
   localparam int MAX_PRINTED   = 50;
   localparam longint LIMIT_NS  = 64'd5_000_000;

   // One output beat: a decoded byte or the stream status.
   typedef struct packed {
      logic [BYTE_W-1:0] value;
      logic              is_data;
      logic              run_last;
      logic              done;
      logic              length_met;
   } decoded_type;

   // How a directed row is checked.
   typedef enum logic [1:0] {
      CHK_MODEL,
      CHK_NONE,
      CHK_ONE
   } row_check_type;

   typedef struct packed {
      logic                 set_len;
      logic [OUT_LEN_W-1:0] new_len;
      logic [BYTE_W-1:0]    data;
      logic                 first;
      logic                 last;
      row_check_type        check;
      decoded_type          want;
   } script_row_type;

   localparam decoded_type NO_REC = '0;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [BYTE_W-1:0]    req_in_byte = '0;
   logic                 req_first_byte = 1'b0;
   logic                 req_last_byte = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [BYTE_W-1:0]    rsp_out_byte;
   logic                 rsp_byte_valid;
   logic                 rsp_run_last;
   logic                 rsp_done_res;
   logic                 rsp_length_met;
   logic                 csr_wr_en = 1'b0;
   logic [OUT_LEN_W-1:0] csr_wr_data = '0;

   lzss_stream_decompressor dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .req_first_byte (req_first_byte),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_run_last   (rsp_run_last),
      .rsp_done_res   (rsp_done_res),
      .rsp_length_met (rsp_length_met),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   // Decoder model state.
   logic [BYTE_W-1:0]    win_mem [WIN_SIZE];
   logic [OFF_W-1:0]     win_head;
   logic [BUF_W-1:0]     bit_buf;
   int unsigned          bit_cnt;
   phase_type            tok_phase;
   logic [OFF_W-1:0]     copy_src;
   logic [OUT_LEN_W-1:0] produced;
   logic                 halted;
   logic [OUT_LEN_W-1:0] length_limit;

   decoded_type    beat_out [$];
   decoded_type    decoded_q [$];
   script_row_type script [$];
   bit             stream_bits [$];
   logic [7:0]     stream_bytes [$];
   logic           req_took = 1'b0;
   logic           calm = 1'b0;
   int             error_count = 0;

   always #5 clock = ~clock;

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   initial begin
      #(LIMIT_NS);
      $display("lzss_stream_decompressor_tb: done, errors");
      $finish;
   end

   // Receiver side: random stalls except during the calm stretch.
   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
   end

   // Record whether a request beat was taken at this edge.
   always @(posedge clock) begin
      req_took <= !reset && req_valid && !req_stall;
   end

   task automatic flag_error(input string msg);
      if (error_count < MAX_PRINTED) begin
         $display("ERROR %0t: %s", $time, msg);
      end
      error_count++;
   endtask

   function automatic decoded_type data_rec(input logic [BYTE_W-1:0] v);
      return {v, 1'b1, 1'b0, 1'b0, 1'b0};
   endfunction

   function automatic decoded_type status_rec(input logic met);
      return {8'h00, 1'b0, 1'b0, 1'b1, met};
   endfunction

   function automatic void clear_stream();
      for (int i = 0; i < WIN_SIZE; i++) win_mem[i] = '0;
      win_head     = 1;
      bit_buf      = '0;
      bit_cnt      = 0;
      tok_phase    = PH_FLAG;
      copy_src     = '0;
      produced     = '0;
      halted       = 1'b0;
   endfunction

   // Every decoded byte is returned and also written at the window head.
   function automatic void emit_decoded(input logic [BYTE_W-1:0] v);
      beat_out.push_back(data_rec(v));
      win_mem[win_head] = v;
      win_head = win_head + 1'b1;
      produced = produced + 1'b1;
   endfunction

   // Decode one compressed byte and collect the beats it causes in beat_out.
   function automatic void decode_beat(input logic [BYTE_W-1:0] b, input logic f,
                                       input logic l);
      int unsigned need;
      int unsigned val;
      int unsigned run_len;
      decoded_type tail;
      beat_out.delete();
      if (f) clear_stream();
      if (halted) return;
      bit_buf = {bit_buf[BUF_W-9:0], b};
      bit_cnt += 8;
      while (1) begin
         if (produced >= length_limit) begin
            halted = 1'b1;
            beat_out.push_back(status_rec(1'b1));
            break;
         end
         case (tok_phase)
            PH_FLAG:    need = 1;
            PH_LITERAL: need = 8;
            PH_OFFSET:  need = OFF_W;
            default:    need = LEN_W;
         endcase
         // Past the last byte the stream is padded with zero bits.
         if (bit_cnt < need) begin
            if (!l) break;
            bit_buf = {bit_buf[BUF_W-9:0], 8'h00};
            bit_cnt += 8;
            continue;
         end
         val = (bit_buf >> (bit_cnt - need)) & ((1 << need) - 1);
         bit_cnt -= need;
         case (tok_phase)
            PH_FLAG: begin
               tok_phase = (val != 0) ? PH_LITERAL : PH_OFFSET;
            end
            PH_LITERAL: begin
               emit_decoded(val[BYTE_W-1:0]);
               tok_phase = PH_FLAG;
            end
            PH_OFFSET: begin
               // Offset zero is the end marker.
               if (val == 0) begin
                  tok_phase = PH_FLAG;
                  halted = 1'b1;
                  beat_out.push_back(status_rec(1'b0));
                  break;
               end
               copy_src = val[OFF_W-1:0];
               tok_phase = PH_LENGTH;
            end
            default: begin
               // Copy from the window; the read address wraps and the copy
               // stops early once the expected length is reached.
               run_len = val + MIN_M;
               for (int i = 0; i < run_len; i++) begin
                  emit_decoded(win_mem[(int'(copy_src) + i) & (WIN_SIZE - 1)]);
                  if (produced >= length_limit) break;
               end
               tok_phase = PH_FLAG;
            end
         endcase
      end
      if (beat_out.size() > 0) begin
         tail = beat_out.pop_back();
         tail.run_last = 1'b1;
         beat_out.push_back(tail);
      end
   endfunction

   function automatic void push_bits(input int unsigned v, input int w);
      for (int i = w - 1; i >= 0; i--) stream_bits.push_back(v[i]);
   endfunction

   // Build a well-formed compressed stream of random tokens in stream_bytes.
   function automatic void build_stream(input int n_tok);
      int unsigned made;
      int unsigned off;
      int unsigned run;
      logic [7:0]  acc;
      stream_bits.delete();
      stream_bytes.delete();
      made = 0;
      for (int t = 0; t < n_tok; t++) begin
         if ($urandom_range(99) < 55) begin
            push_bits(1, 1);
            push_bits($urandom_range(255), 8);
            made++;
         end else begin
            // Mostly refer back to bytes already written in this stream.
            if (made > 0 && $urandom_range(9) < 8) off = $urandom_range(made, 1);
            else off = $urandom_range(WIN_SIZE - 1, 1);
            run = $urandom_range((1 << LEN_W) - 1, 0);
            push_bits(0, 1);
            push_bits(off, OFF_W);
            push_bits(run, LEN_W);
            made += run + MIN_M;
         end
      end
      if ($urandom_range(9) < 7) begin
         push_bits(0, 1);
         push_bits(0, OFF_W);
      end
      while (stream_bits.size() % 8 != 0) stream_bits.push_back(1'b0);
      for (int k = 0; k < stream_bits.size(); k += 8) begin
         acc = '0;
         for (int j = 0; j < 8; j++) acc = {acc[6:0], stream_bits[k + j]};
         stream_bytes.push_back(acc);
      end
   endfunction

   // Present one compressed byte, wait until it is taken, then update the model.
   task automatic send_beat(input logic [BYTE_W-1:0] b, input logic f, input logic l,
                            input logic use_model);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_in_byte    <= b;
      req_first_byte <= f;
      req_last_byte  <= l;
      do @(negedge clock); while (!req_took);
      decode_beat(b, f, l);
      if (use_model) begin
         foreach (beat_out[k]) decoded_q.push_back(beat_out[k]);
      end
   endtask

   // Let every expected beat arrive and the block go quiet.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (decoded_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_length(input logic [OUT_LEN_W-1:0] v);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      length_limit = v;
   endtask

   task automatic add_row(input logic set_len, input logic [OUT_LEN_W-1:0] new_len,
                          input logic [BYTE_W-1:0] data, input logic first,
                          input logic last, input row_check_type check,
                          input decoded_type want);
      script.push_back({set_len, new_len, data, first, last, check, want});
   endtask

   // Compare each output beat with the oldest expectation.
   always @(posedge clock) begin : check_output
      decoded_type got;
      decoded_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_out_byte, rsp_byte_valid, rsp_run_last, rsp_done_res, rsp_length_met};
         if (decoded_q.size() == 0) begin
            flag_error($sformatf("unexpected output beat %h", got));
         end else begin
            want = decoded_q.pop_front();
            if (got.value !== want.value)
               flag_error($sformatf("out_byte %h, want %h", got.value, want.value));
            if (got.is_data !== want.is_data)
               flag_error($sformatf("byte_valid %b, want %b", got.is_data, want.is_data));
            if (got.run_last !== want.run_last)
               flag_error($sformatf("run_last %b, want %b", got.run_last, want.run_last));
            if (got.done !== want.done)
               flag_error($sformatf("done_res %b, want %b", got.done, want.done));
            if (got.length_met !== want.length_met)
               flag_error($sformatf("length_met %b, want %b", got.length_met,
                                    want.length_met));
         end
      end
   end

   initial begin : stimulus
      script_row_type       row;
      logic [OUT_LEN_W-1:0] phase_len [6];
      int                   phase_budget [6];
      int                   used;
      int                   cut;
      int                   pick;
      logic                 noise;
      logic                 do_last;

      clear_stream();
      length_limit = '0;

      // Zero expected length stops at once; later bytes are ignored.
      add_row(1, 32'd0, 8'hFF, 1, 0, CHK_ONE, status_rec(1'b1));
      add_row(0, 32'd0, 8'h00, 0, 0, CHK_NONE, NO_REC);
      // Largest length: literal 0xFF, a longest self-overlapping match, a zero
      // literal, then zero padding runs into the end marker.
      add_row(1, 32'hFFFF_FFFF, 8'hFF, 1, 0, CHK_NONE, NO_REC);
      add_row(0, 32'd0, 8'h80, 0, 0, CHK_ONE, data_rec(8'hFF));
      add_row(0, 32'd0, 8'h03, 0, 0, CHK_NONE, NO_REC);
      add_row(0, 32'd0, 8'hF0, 0, 0, CHK_MODEL, NO_REC);
      add_row(0, 32'd0, 8'h00, 0, 1, CHK_MODEL, NO_REC);
      // Length of five is reached in the middle of a match.
      add_row(1, 32'd5, 8'hA0, 1, 0, CHK_NONE, NO_REC);
      add_row(0, 32'd0, 8'h80, 0, 0, CHK_ONE, data_rec(8'h41));
      add_row(0, 32'd0, 8'h03, 0, 0, CHK_NONE, NO_REC);
      add_row(0, 32'd0, 8'hE0, 0, 0, CHK_MODEL, NO_REC);
      // Length lowered below the byte count while the stream is open.
      add_row(1, 32'd100, 8'hA0, 1, 0, CHK_NONE, NO_REC);
      add_row(0, 32'd0, 8'h80, 0, 0, CHK_ONE, data_rec(8'h41));
      add_row(1, 32'd1, 8'h03, 0, 0, CHK_ONE, status_rec(1'b1));
      // Highest offset: the copy wraps past the top of the window.
      add_row(1, 32'hFFFF_FFFF, 8'h7F, 1, 0, CHK_NONE, NO_REC);
      add_row(0, 32'd0, 8'hFC, 0, 0, CHK_NONE, NO_REC);
      add_row(0, 32'd0, 8'h00, 0, 1, CHK_MODEL, NO_REC);
      // A single byte that is both first and last, then a restart mid-token.
      add_row(0, 32'd0, 8'hFF, 1, 1, CHK_MODEL, NO_REC);
      add_row(0, 32'd0, 8'hA0, 1, 0, CHK_NONE, NO_REC);
      add_row(0, 32'd0, 8'hA0, 1, 0, CHK_NONE, NO_REC);
      add_row(0, 32'd0, 8'h80, 0, 1, CHK_MODEL, NO_REC);

      wait (reset == 1'b0);
      @(negedge clock);

      foreach (script[r]) begin
         row = script[r];
         if (row.set_len) set_length(row.new_len);
         send_beat(row.data, row.first, row.last, row.check == CHK_MODEL);
         if (row.check == CHK_ONE) begin
            row.want.run_last = 1'b1;
            decoded_q.push_back(row.want);
         end
      end

      // Random streams under several length settings; the last phase runs calm.
      phase_len[0] = 32'hFFFF_FFFF;        phase_budget[0] = 100;
      phase_len[1] = $urandom_range(120, 20); phase_budget[1] = 80;
      phase_len[2] = 32'd0;                phase_budget[2] = 10;
      phase_len[3] = 32'd1;                phase_budget[3] = 15;
      phase_len[4] = $urandom_range(10, 3); phase_budget[4] = 40;
      phase_len[5] = 32'hFFFF_FFFF;        phase_budget[5] = 65;

      for (int ph = 0; ph < 6; ph++) begin
         set_length(phase_len[ph]);
         calm = (ph == 5);
         used = 0;
         while (used < phase_budget[ph]) begin
            noise = ($urandom_range(99) < 12);
            if (noise) begin
               stream_bytes.delete();
               repeat ($urandom_range(6, 1)) stream_bytes.push_back(8'($urandom_range(255)));
            end else begin
               build_stream($urandom_range(12, 1));
               // Now and then cut the stream short or corrupt one bit.
               if ($urandom_range(9) == 0) begin
                  if ($urandom_range(1) == 0) begin
                     cut = $urandom_range(stream_bytes.size() - 1, 0);
                     repeat (cut) void'(stream_bytes.pop_back());
                  end else begin
                     pick = $urandom_range(stream_bytes.size() - 1, 0);
                     stream_bytes[pick] = stream_bytes[pick] ^ (8'h01 << $urandom_range(7));
                  end
               end
            end
            do_last = ($urandom_range(99) < 85);
            foreach (stream_bytes[k]) begin
               if (noise)
                  send_beat(stream_bytes[k], 1'($urandom_range(1)), 1'($urandom_range(1)),
                            1'b1);
               else
                  send_beat(stream_bytes[k], k == 0, do_last && (k == stream_bytes.size() - 1),
                            1'b1);
               used++;
            end
         end
      end

      calm = 1'b0;
      wait_drained();
      if (error_count == 0) begin
         $display("lzss_stream_decompressor_tb: done, clean");
      end else begin
         $display("lzss_stream_decompressor_tb: done, errors");
      end
      $finish;
   end

endmodule
